FILE: sv/tea_pkg.sv
// Shared types and constants for the TEA block cipher unit.
// Depends on nothing; tea_ctrl, tea_dp, the top level and the bench import it.
package tea_pkg;

  localparam int unsigned WORD_W = 32;
  localparam int unsigned ROUND_W = 8;
  localparam int unsigned CFG_ADDR_W = 5;
  localparam int unsigned CFG_DATA_W = 32;

  localparam logic [WORD_W-1:0] TEA_DELTA = 32'h9e3779b9;
  localparam int unsigned SHIFT_LEFT_AMT = 4;
  localparam int unsigned SHIFT_RIGHT_AMT = 5;

  localparam logic CMD_ENCRYPT = 1'b0;
  localparam logic CMD_DECRYPT = 1'b1;

  typedef enum logic [2:0] {
    REG_KEY0   = 3'd0,
    REG_KEY1   = 3'd1,
    REG_KEY2   = 3'd2,
    REG_KEY3   = 3'd3,
    REG_ROUNDS = 3'd4
  } tea_reg_idx_t;

  localparam logic [ROUND_W-1:0] ROUNDS_RESET = 8'd32;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_DONE
  } tea_state_t;

  typedef struct packed {
    logic load;
    logic step;
    logic out_load;
  } tea_cmd_t;

endpackage

FILE: sv/tea_in_if.sv
// Input channel of the TEA unit: handshake plus command and block words.
// Depends on nothing.
interface tea_in_if;
  logic        valid;
  logic        ready;
  logic        command;
  logic [31:0] block_left;
  logic [31:0] block_right;

  modport source(output valid, output command, output block_left, output block_right,
                 input ready);
  modport sink(input valid, input command, input block_left, input block_right,
               output ready);
endinterface

FILE: sv/tea_out_if.sv
// Result channel of the TEA unit: handshake plus the processed block words.
// Depends on nothing.
interface tea_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] result_left;
  logic [31:0] result_right;

  modport source(output valid, output result_left, output result_right, input ready);
  modport sink(input valid, input result_left, input result_right, output ready);
endinterface

FILE: sv/tea_ctrl.sv
// Round sequencer of the TEA unit: state machine, round counter and result valid.
// Depends on tea_pkg.
module tea_ctrl
  import tea_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [ROUND_W-1:0] round_count,
  output logic               out_valid,
  input  logic               out_ready,
  output tea_cmd_t           cmd
);

  tea_state_t         state_r, state_nxt;
  logic [ROUND_W-1:0] cnt_r, cnt_nxt;
  logic               out_valid_r, out_valid_nxt;
  logic               in_fire;

  assign in_ready = (state_r == ST_IDLE);
  assign in_fire = in_valid && in_ready;
  assign out_valid = out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      cnt_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cnt_nxt = cnt_r;
    cmd = '0;
    unique case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          cmd.load = 1'b1;
          cnt_nxt = round_count;
          state_nxt = (round_count == '0) ? ST_DONE : ST_RUN;
        end
      end
      ST_RUN: begin
        cmd.step = 1'b1;
        cnt_nxt = cnt_r - 1'b1;
        if (cnt_r == ROUND_W'(1)) begin
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        if (!out_valid_r || out_ready) begin
          cmd.out_load = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    if (cmd.out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  // A pending result is never overwritten before its transfer.
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |-> (!out_valid_r || out_ready))
    else $error("result register loaded while a result was pending");

  // An accepted item always leaves the idle state.
  a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> (state_r != ST_IDLE))
    else $error("accepted item did not start processing");

  // The last round is followed by the result stage.
  a_last_round: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_RUN && cnt_r == ROUND_W'(1)) |=> (state_r == ST_DONE))
    else $error("round counter did not end the run");

endmodule

FILE: sv/tea_dp.sv
// Datapath of the TEA unit: block words, running sum, one round per step, result register.
// Depends on tea_pkg.
module tea_dp
  import tea_pkg::*;
(
  input  logic               clk,
  input  tea_cmd_t           cmd,
  input  logic               command,
  input  logic [WORD_W-1:0]  block_left,
  input  logic [WORD_W-1:0]  block_right,
  input  logic [WORD_W-1:0]  key_word0,
  input  logic [WORD_W-1:0]  key_word1,
  input  logic [WORD_W-1:0]  key_word2,
  input  logic [WORD_W-1:0]  key_word3,
  input  logic [ROUND_W-1:0] round_count,
  output logic [WORD_W-1:0]  result_left,
  output logic [WORD_W-1:0]  result_right
);

  function automatic logic [WORD_W-1:0] mix_word(input logic [WORD_W-1:0] w,
                                                 input logic [WORD_W-1:0] ka,
                                                 input logic [WORD_W-1:0] kb,
                                                 input logic [WORD_W-1:0] acc);
    logic [WORD_W-1:0] a;
    logic [WORD_W-1:0] b;
    logic [WORD_W-1:0] c;
    a = (w << SHIFT_LEFT_AMT) + ka;
    b = w + acc;
    c = (w >> SHIFT_RIGHT_AMT) + kb;
    return a ^ b ^ c;
  endfunction

  logic                      mode_r, mode_nxt;
  logic [WORD_W-1:0]         lw_r, lw_nxt;
  logic [WORD_W-1:0]         rw_r, rw_nxt;
  logic [WORD_W-1:0]         acc_r, acc_nxt;
  logic [WORD_W-1:0]         res_left_r, res_left_nxt;
  logic [WORD_W-1:0]         res_right_r, res_right_nxt;
  logic [WORD_W+ROUND_W-1:0] dec_start;
  logic [WORD_W-1:0]         enc_l, enc_r, dec_l, dec_r;

  assign dec_start = (WORD_W + ROUND_W)'(TEA_DELTA) * (WORD_W + ROUND_W)'(round_count);

  always_comb begin
    enc_l = lw_r + mix_word(rw_r, key_word0, key_word1, acc_r);
    enc_r = rw_r + mix_word(enc_l, key_word2, key_word3, acc_r);
    dec_r = rw_r - mix_word(lw_r, key_word2, key_word3, acc_r);
    dec_l = lw_r - mix_word(dec_r, key_word0, key_word1, acc_r);
  end

  always_comb begin
    mode_nxt = mode_r;
    lw_nxt = lw_r;
    rw_nxt = rw_r;
    acc_nxt = acc_r;
    res_left_nxt = res_left_r;
    res_right_nxt = res_right_r;
    if (cmd.load) begin
      mode_nxt = command;
      lw_nxt = block_left;
      rw_nxt = block_right;
      acc_nxt = (command == CMD_DECRYPT) ? dec_start[WORD_W-1:0] : TEA_DELTA;
    end else if (cmd.step) begin
      if (mode_r == CMD_DECRYPT) begin
        lw_nxt = dec_l;
        rw_nxt = dec_r;
        acc_nxt = acc_r - TEA_DELTA;
      end else begin
        lw_nxt = enc_l;
        rw_nxt = enc_r;
        acc_nxt = acc_r + TEA_DELTA;
      end
    end
    if (cmd.out_load) begin
      res_left_nxt = lw_r;
      res_right_nxt = rw_r;
    end
  end

  always_ff @(posedge clk) begin
    mode_r <= mode_nxt;
    lw_r <= lw_nxt;
    rw_r <= rw_nxt;
    acc_r <= acc_nxt;
    res_left_r <= res_left_nxt;
    res_right_r <= res_right_nxt;
  end

  assign result_left = res_left_r;
  assign result_right = res_right_r;

endmodule

FILE: sv/tea_block_cipher_unit.sv
// Top level of the TEA block cipher unit: configuration registers and the two submodules.
// Depends on tea_pkg, tea_in_if, tea_out_if, tea_ctrl and tea_dp.
//
//   channel   direction  handshake        payload
//   in_chan   in         valid/ready      command, block_left, block_right
//   out_chan  out        valid/ready      result_left, result_right
//   cfg (APB) in         psel/penable     paddr, pwdata, prdata
//
// An item is loaded at its transfer, runs round_count rounds at one round per cycle in the
// round unit, and is then loaded into the result register, which makes the result valid.
// A new item is taken the cycle after the result register is loaded, while it waits.
// If a result is still waiting, the finished item holds until that transfer.
// Reset is synchronous and active low; it sets the keys to zero and the round count to 32.
module tea_block_cipher_unit
  import tea_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  tea_in_if.sink                in_chan,
  tea_out_if.source             out_chan,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [CFG_DATA_W-1:0] pwdata,
  output logic [CFG_DATA_W-1:0] prdata,
  output logic                  pready
);

  logic [WORD_W-1:0]  key0_r, key0_nxt;
  logic [WORD_W-1:0]  key1_r, key1_nxt;
  logic [WORD_W-1:0]  key2_r, key2_nxt;
  logic [WORD_W-1:0]  key3_r, key3_nxt;
  logic [ROUND_W-1:0] rounds_r, rounds_nxt;
  logic               cfg_wr;
  tea_reg_idx_t       reg_idx;
  tea_cmd_t           cmd;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;
  assign reg_idx = tea_reg_idx_t'(paddr[CFG_ADDR_W-1:2]);

  always_comb begin
    key0_nxt = key0_r;
    key1_nxt = key1_r;
    key2_nxt = key2_r;
    key3_nxt = key3_r;
    rounds_nxt = rounds_r;
    if (cfg_wr) begin
      unique case (reg_idx)
        REG_KEY0:   key0_nxt = pwdata;
        REG_KEY1:   key1_nxt = pwdata;
        REG_KEY2:   key2_nxt = pwdata;
        REG_KEY3:   key3_nxt = pwdata;
        REG_ROUNDS: rounds_nxt = pwdata[ROUND_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_KEY0:   prdata = key0_r;
      REG_KEY1:   prdata = key1_r;
      REG_KEY2:   prdata = key2_r;
      REG_KEY3:   prdata = key3_r;
      REG_ROUNDS: prdata = CFG_DATA_W'(rounds_r);
      default:    prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key0_r <= '0;
      key1_r <= '0;
      key2_r <= '0;
      key3_r <= '0;
      rounds_r <= ROUNDS_RESET;
    end else begin
      key0_r <= key0_nxt;
      key1_r <= key1_nxt;
      key2_r <= key2_nxt;
      key3_r <= key3_nxt;
      rounds_r <= rounds_nxt;
    end
  end

  tea_ctrl u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_chan.valid),
    .in_ready    (in_chan.ready),
    .round_count (rounds_r),
    .out_valid   (out_chan.valid),
    .out_ready   (out_chan.ready),
    .cmd         (cmd)
  );

  tea_dp u_dp (
    .clk          (clk),
    .cmd          (cmd),
    .command      (in_chan.command),
    .block_left   (in_chan.block_left),
    .block_right  (in_chan.block_right),
    .key_word0    (key0_r),
    .key_word1    (key1_r),
    .key_word2    (key2_r),
    .key_word3    (key3_r),
    .round_count  (rounds_r),
    .result_left  (out_chan.result_left),
    .result_right (out_chan.result_right)
  );

endmodule

FILE: bench/tb_top.sv
// Self-checking bench for tea_block_cipher_unit: it predicts every processed block
// from its own copy of the key and round count and compares each result transfer.
// Depends on tea_pkg, tea_in_if, tea_out_if and the unit itself.
module tb_top;
  import tea_pkg::*;

  typedef struct packed {
    logic [WORD_W-1:0] left;
    logic [WORD_W-1:0] right;
  } tea_block_t;

  localparam logic [2:0] REG_SPARE_LO = 3'd5;
  localparam logic [2:0] REG_SPARE_HI = 3'd7;

  class block_scoreboard;
    logic [WORD_W-1:0] key_words[4];
    logic [ROUND_W-1:0] rounds;
    tea_block_t expected_blocks[$];
    int errors;

    function new();
      key_words = '{default: '0};
      rounds = ROUNDS_RESET;
      errors = 0;
    endfunction

    task report_mismatch(string what);
      errors++;
      $display("mismatch at %0t: %s", $time, what);
    endtask

    function void set_register(logic [2:0] idx, logic [31:0] value);
      case (idx)
        REG_KEY0: key_words[0] = value;
        REG_KEY1: key_words[1] = value;
        REG_KEY2: key_words[2] = value;
        REG_KEY3: key_words[3] = value;
        REG_ROUNDS: rounds = value[ROUND_W-1:0];
        default: ;
      endcase
    endfunction

    function logic [WORD_W-1:0] feistel_mix(logic [WORD_W-1:0] w, logic [WORD_W-1:0] ka,
                                            logic [WORD_W-1:0] kb, logic [WORD_W-1:0] total);
      return ((w << SHIFT_LEFT_AMT) + ka) ^ (w + total) ^ ((w >> SHIFT_RIGHT_AMT) + kb);
    endfunction

    function tea_block_t tea_transform(logic cmd, tea_block_t blk);
      logic [WORD_W-1:0] total;
      tea_block_t res;
      res = blk;
      if (cmd == CMD_ENCRYPT) begin
        total = '0;
        for (int r = 0; r < rounds; r++) begin
          total = total + TEA_DELTA;
          res.left = res.left + feistel_mix(res.right, key_words[0], key_words[1], total);
          res.right = res.right + feistel_mix(res.left, key_words[2], key_words[3], total);
        end
      end else begin
        total = TEA_DELTA * rounds;
        for (int r = 0; r < rounds; r++) begin
          res.right = res.right - feistel_mix(res.left, key_words[2], key_words[3], total);
          res.left = res.left - feistel_mix(res.right, key_words[0], key_words[1], total);
          total = total - TEA_DELTA;
        end
      end
      return res;
    endfunction

    function int pending();
      return expected_blocks.size();
    endfunction

    function void note_block(logic cmd, tea_block_t blk);
      expected_blocks.push_back(tea_transform(cmd, blk));
    endfunction

    task check_block(tea_block_t got);
      tea_block_t want;
      if (expected_blocks.size() == 0) begin
        report_mismatch($sformatf("result %h_%h with no block pending", got.left, got.right));
      end else begin
        want = expected_blocks.pop_front();
        if (got.left !== want.left) begin
          report_mismatch($sformatf("result_left %h, expected %h", got.left, want.left));
        end
        if (got.right !== want.right) begin
          report_mismatch($sformatf("result_right %h, expected %h", got.right, want.right));
        end
      end
    endtask

    task report_leftovers();
      if (expected_blocks.size() != 0) begin
        report_mismatch($sformatf("%0d blocks never came out", expected_blocks.size()));
      end
    endtask
  endclass

  logic clk = 1'b0;
  logic rst_n;
  logic psel;
  logic penable;
  logic pwrite;
  logic [CFG_ADDR_W-1:0] paddr;
  logic [CFG_DATA_W-1:0] pwdata;
  logic [CFG_DATA_W-1:0] prdata;
  logic pready;
  bit calm = 1'b0;
  int stall_cycles = 0;
  block_scoreboard ledger = new();

  tea_in_if in_chan();
  tea_out_if out_chan();

  tea_block_cipher_unit dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_chan(in_chan),
    .out_chan(out_chan),
    .psel(psel),
    .penable(penable),
    .pwrite(pwrite),
    .paddr(paddr),
    .pwdata(pwdata),
    .prdata(prdata),
    .pready(pready)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    if (stall_cycles != 0) begin
      stall_cycles <= stall_cycles - 1;
    end else if (!calm && $urandom_range(0, 5) == 0) begin
      out_chan.ready <= 1'b0;
      stall_cycles <= $urandom_range(1, 13) - 1;
    end else begin
      out_chan.ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (in_chan.valid && in_chan.ready) begin
        ledger.note_block(in_chan.command, {in_chan.block_left, in_chan.block_right});
      end
      if (out_chan.valid && out_chan.ready) begin
        ledger.check_block({out_chan.result_left, out_chan.result_right});
      end
    end
  end

  function automatic logic [WORD_W-1:0] random_word();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return '1;
      default: return $urandom;
    endcase
  endfunction

  task automatic send_block(logic cmd, tea_block_t blk);
    in_chan.valid <= 1'b1;
    in_chan.command <= cmd;
    in_chan.block_left <= blk.left;
    in_chan.block_right <= blk.right;
    do @(posedge clk); while (!in_chan.ready);
  endtask

  task automatic hold_input(int cycles);
    in_chan.valid <= 1'b0;
    repeat (cycles) @(posedge clk);
  endtask

  task automatic await_results();
    in_chan.valid <= 1'b0;
    do @(posedge clk); while (ledger.pending() != 0);
  endtask

  task automatic write_register(logic [2:0] idx, logic [31:0] value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    ledger.set_register(idx, value);
  endtask

  task automatic bus_idle();
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  task automatic load_setting(logic [31:0] k0, logic [31:0] k1, logic [31:0] k2,
                              logic [31:0] k3, logic [31:0] rounds_word);
    write_register(REG_KEY0, k0);
    write_register(REG_KEY1, k1);
    write_register(REG_KEY2, k2);
    write_register(REG_KEY3, k3);
    write_register(REG_ROUNDS, rounds_word);
    bus_idle();
  endtask

  task automatic run_batch(int count);
    tea_block_t blk;
    tea_block_t prior;
    logic cmd;
    prior = '0;
    for (int n = 0; n < count; n++) begin
      // Some decrypts take back the last ciphertext, so round trips are exercised.
      if ($urandom_range(0, 4) == 0) begin
        cmd = CMD_DECRYPT;
        blk = prior;
      end else begin
        cmd = 1'($urandom_range(0, 1));
        blk = {random_word(), random_word()};
      end
      if (cmd == CMD_ENCRYPT) begin
        prior = ledger.tea_transform(cmd, blk);
      end
      if (!calm && $urandom_range(0, 3) == 0) begin
        hold_input($urandom_range(1, 13));
      end
      send_block(cmd, blk);
    end
    await_results();
  endtask

  initial begin
    tea_block_t blk;
    logic [31:0] rounds_word;
    logic [7:0] rc;
    in_chan.valid = 1'b0;
    in_chan.command = CMD_ENCRYPT;
    in_chan.block_left = '0;
    in_chan.block_right = '0;
    out_chan.ready = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    rst_n = 1'b0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Settings after reset: zero key, 32 rounds.
    send_block(CMD_ENCRYPT, '0);
    send_block(CMD_DECRYPT, '0);
    send_block(CMD_ENCRYPT, '1);
    send_block(CMD_DECRYPT, '1);
    await_results();

    // Zero rounds pass the block through; writes to spare addresses must be ignored.
    load_setting('1, '1, '1, '1, 32'd0);
    write_register(REG_SPARE_LO, $urandom);
    write_register(REG_SPARE_HI, $urandom);
    bus_idle();
    send_block(CMD_ENCRYPT, {32'h0123_4567, 32'h89ab_cdef});
    send_block(CMD_DECRYPT, {32'hfedc_ba98, 32'h7654_3210});
    await_results();

    write_register(REG_ROUNDS, 32'd1);
    bus_idle();
    send_block(CMD_ENCRYPT, '1);
    send_block(CMD_DECRYPT, {32'haaaa_aaaa, 32'h5555_5555});
    send_block(CMD_ENCRYPT, {32'h8000_0000, 32'h0000_0001});
    await_results();

    write_register(REG_ROUNDS, 32'd255);
    bus_idle();
    send_block(CMD_ENCRYPT, '0);
    send_block(CMD_DECRYPT, '1);
    await_results();

    load_setting($urandom, $urandom, $urandom, $urandom, 32'd32);
    blk = {$urandom, $urandom};
    send_block(CMD_ENCRYPT, blk);
    send_block(CMD_DECRYPT, ledger.tea_transform(CMD_ENCRYPT, blk));
    blk = {$urandom, $urandom};
    send_block(CMD_DECRYPT, blk);
    send_block(CMD_ENCRYPT, ledger.tea_transform(CMD_DECRYPT, blk));
    await_results();

    for (int p = 0; p < 8; p++) begin
      case (p)
        0: rc = 8'd32;
        1: rc = 8'd0;
        2: rc = 8'd1;
        3: rc = 8'd255;
        default: rc = 8'($urandom_range(2, 254));
      endcase
      rounds_word = $urandom;
      rounds_word[7:0] = rc;
      if (p == 7) begin
        calm = 1'b1;
      end
      load_setting(random_word(), random_word(), random_word(), random_word(), rounds_word);
      run_batch(175);
    end

    repeat (300) @(posedge clk);
    ledger.report_leftovers();
    if (ledger.errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  initial begin
    #30_000_000;
    $display("TB_ERROR");
    $finish;
  end

endmodule
